FILE: hdl/get_pkg.sv
// ----------------------------------------------------------------------------
// get_pkg
// Shared constants, types and helpers of the Prewitt edge threshold block.
// ----------------------------------------------------------------------------
package get_pkg;

	// Image limits.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_WIDTH  = 3;

	// Field and datapath widths.
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int CFG_W   = 11;
	localparam int LUMA_W  = 16;
	localparam int ENTRY_W = 2 * LUMA_W;
	localparam int SUM_W   = LUMA_W + 3;
	localparam int SQ_W    = 2 * SUM_W - 2;
	localparam int MAG_W   = SQ_W + 1;
	localparam int FRAC_W  = 8;
	localparam int LIM_W   = 2 * CFG_W + 2 * FRAC_W;

	// APB port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Q8 luma weights.
	localparam int W_RED   = 77;
	localparam int W_GREEN = 150;
	localparam int W_BLUE  = 29;

	// Register reset values.
	localparam logic [CFG_W-1:0] THRESHOLD_RESET = CFG_W'(200);
	localparam logic [CFG_W-1:0] WIDTH_RESET     = CFG_W'(640);

	// Register indexes.
	typedef enum logic {
		REG_THRESHOLD,
		REG_WIDTH
	} reg_idx_t;

	typedef logic [LUMA_W-1:0] luma_t;

	// One new window column, handed from the line store stage to the judge.
	typedef struct packed {
		logic             valid;
		logic             emit;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		luma_t            upper;
		luma_t            middle;
		luma_t            luma;
	} column_t;

	// Exact Q8 luma of one pixel.
	function automatic luma_t to_luma(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		to_luma = LUMA_W'(W_RED * int'(r) + W_GREEN * int'(g) + W_BLUE * int'(b));
	endfunction

endpackage

FILE: hdl/get_ram.sv
// ----------------------------------------------------------------------------
// get_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module get_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and read port; the read word holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/get_front.sv
// ----------------------------------------------------------------------------
// get_front
// Pixel position tracking, luma conversion and the two-line luma store.
// ----------------------------------------------------------------------------
module get_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [7:0]                blue,
	input  logic [7:0]                green,
	input  logic [7:0]                red,
	input  logic                      start_of_frame,
	input  logic [get_pkg::CFG_W-1:0] image_width,
	output get_pkg::column_t          col_s1
);
	import get_pkg::*;

	logic                 accept;
	logic [CFG_W-1:0]     width_eff;
	logic [COL_W-1:0]     col_q, cur_col, col_d;
	logic [ROW_W-1:0]     row_q, cur_row, row_d;
	luma_t                luma_in;
	logic                 valid_s1, emit_s1, fwd_s1;
	logic [COL_W-1:0]     c_s1;
	logic [ROW_W-1:0]     row_s1;
	luma_t                luma_s1;
	logic [ENTRY_W-1:0]   fwd_entry_s1, rdata, entry, wdata;

	function automatic logic [ROW_W-1:0] row_inc(logic [ROW_W-1:0] r);
		row_inc = (r == ROW_W'(MAX_HEIGHT - 1)) ? '0 : r + 1'b1;
	endfunction

	assign accept  = in_valid && en;
	assign luma_in = to_luma(blue, green, red);

	// Clamp the programmed width into the supported range.
	always_comb begin
		priority if (image_width < CFG_W'(MIN_WIDTH)) begin
			width_eff = CFG_W'(MIN_WIDTH);
		end else if (image_width > CFG_W'(MAX_WIDTH)) begin
			width_eff = CFG_W'(MAX_WIDTH);
		end else begin
			width_eff = image_width;
		end
	end

	// Position of the incoming pixel and of the one after it.
	always_comb begin
		priority if (start_of_frame) begin
			cur_col = '0;
			cur_row = '0;
		end else if (CFG_W'(col_q) >= width_eff) begin
			cur_col = '0;
			cur_row = row_inc(row_q);
		end else begin
			cur_col = col_q;
			cur_row = row_q;
		end
		if (CFG_W'(cur_col) + CFG_W'(1) >= width_eff) begin
			col_d = '0;
			row_d = row_inc(cur_row);
		end else begin
			col_d = cur_col + 1'b1;
			row_d = cur_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload; forward the entry written this cycle if the new word reads it.
	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1         <= cur_col;
			row_s1       <= cur_row;
			luma_s1      <= luma_in;
			emit_s1      <= (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2));
			fwd_s1       <= valid_s1 && (c_s1 == cur_col);
			fwd_entry_s1 <= wdata;
		end
	end

	// Line store entry: upper line in the high half, middle line in the low half.
	get_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (en && valid_s1),
		.waddr (c_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (cur_col),
		.rdata (rdata)
	);

	assign entry = fwd_s1 ? fwd_entry_s1 : rdata;
	assign wdata = {entry[LUMA_W-1:0], luma_s1};

	assign col_s1.valid  = valid_s1;
	assign col_s1.emit   = emit_s1;
	assign col_s1.col    = c_s1;
	assign col_s1.row    = row_s1;
	assign col_s1.upper  = entry[ENTRY_W-1:LUMA_W];
	assign col_s1.middle = entry[LUMA_W-1:0];
	assign col_s1.luma   = luma_s1;

endmodule

FILE: hdl/get_judge.sv
// ----------------------------------------------------------------------------
// get_judge
// 3x3 luma window, Prewitt sums, squared magnitude and threshold compare.
// ----------------------------------------------------------------------------
module get_judge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  get_pkg::column_t          col_in,
	input  logic [get_pkg::CFG_W-1:0] edge_threshold,
	output logic                      out_valid,
	output logic                      edge_res,
	output logic [get_pkg::COL_W-1:0] centre_column,
	output logic [get_pkg::ROW_W-1:0] centre_row
);
	import get_pkg::*;

	luma_t                   win_q [9];
	logic                    valid_s2, valid_s3, valid_s4, out_valid_q;
	logic [COL_W-1:0]        col_s2, col_s3, col_s4;
	logic [ROW_W-1:0]        row_s2, row_s3, row_s4;
	logic [SUM_W-1:0]        left, right, top, bottom;
	logic signed [SUM_W-1:0] sx, sy, sx_s3, sy_s3;
	logic signed [2*SUM_W-1:0] px, py;
	logic [SQ_W-1:0]         sqx_s4, sqy_s4;
	logic [2*CFG_W-1:0]      thr_sq_q;
	logic [MAG_W-1:0]        mag;
	logic [LIM_W-1:0]        lim;
	logic                    edge_q;
	logic [COL_W-1:0]        centre_col_q;
	logic [ROW_W-1:0]        centre_row_q;

	function automatic logic [SUM_W-1:0] sum3(luma_t a, luma_t b, luma_t c);
		sum3 = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
	endfunction

	// Window shift: index row*3 + col, column 2 newest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (en && col_in.valid) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= col_in.upper;
			win_q[5] <= col_in.middle;
			win_q[8] <= col_in.luma;
		end
	end

	// Valid chain through the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s2    <= col_in.valid && col_in.emit;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// Prewitt sums over the current window.
	always_comb begin
		left   = sum3(win_q[0], win_q[3], win_q[6]);
		right  = sum3(win_q[2], win_q[5], win_q[8]);
		top    = sum3(win_q[0], win_q[1], win_q[2]);
		bottom = sum3(win_q[6], win_q[7], win_q[8]);
		sx     = $signed(right - left);
		sy     = $signed(bottom - top);
	end

	assign px  = sx_s3 * sx_s3;
	assign py  = sy_s3 * sy_s3;
	assign mag = MAG_W'(sqx_s4) + MAG_W'(sqy_s4);
	assign lim = {thr_sq_q, {(2*FRAC_W){1'b0}}};

	// Threshold square, refreshed every cycle from the register.
	always_ff @(posedge clk) begin
		thr_sq_q <= (2*CFG_W)'(edge_threshold) * (2*CFG_W)'(edge_threshold);
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (en) begin
			col_s2       <= col_in.col;
			row_s2       <= col_in.row;
			sx_s3        <= sx;
			sy_s3        <= sy;
			col_s3       <= col_s2;
			row_s3       <= row_s2;
			sqx_s4       <= px[SQ_W-1:0];
			sqy_s4       <= py[SQ_W-1:0];
			col_s4       <= col_s3;
			row_s4       <= row_s3;
			edge_q       <= LIM_W'(mag) > lim;
			centre_col_q <= col_s4 - 1'b1;
			centre_row_q <= row_s4 - 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign edge_res      = edge_q;
	assign centre_column = centre_col_q;
	assign centre_row    = centre_row_q;

endmodule

FILE: hdl/gradient_edge_threshold_top.sv
// ----------------------------------------------------------------------------
// gradient_edge_threshold_top
// Prewitt 3x3 edge detector with threshold on a raster BGR pixel stream.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pixel word passes stage 1, stage 2, stage 3, stage 4 and the
// output register. Throughput: one pixel word per cycle while no result word is
// waiting; the line store RAM takes a read of the new column and a write of the last.
// Reset: arst_n clears the position counters, window and pipeline valids and
// loads the register defaults; line store contents stay undefined until written.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 blue,
	input  logic [7:0]                 green,
	input  logic [7:0]                 red,
	input  logic                       start_of_frame,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       edge_res,
	output logic [get_pkg::COL_W-1:0]  centre_column,
	output logic [get_pkg::ROW_W-1:0]  centre_row,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [get_pkg::ADDR_W-1:0] paddr,
	input  logic [get_pkg::DATA_W-1:0] pwdata,
	output logic [get_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import get_pkg::*;

	logic             en;
	logic [CFG_W-1:0] threshold_q, width_q;
	reg_idx_t         reg_idx;
	column_t          col_s1;

	// The whole pipeline advances unless a result word is waiting.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign pready   = 1'b1;
	assign reg_idx  = reg_idx_t'(paddr[2]);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			width_q     <= WIDTH_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[CFG_W-1:0];
				REG_WIDTH:     width_q     <= pwdata[CFG_W-1:0];
				default:       ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			REG_WIDTH:     prdata = DATA_W'(width_q);
			default:       prdata = '0;
		endcase
	end

	get_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (in_valid),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.start_of_frame (start_of_frame),
		.image_width    (width_q),
		.col_s1         (col_s1)
	);

	get_judge u_judge (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.col_in         (col_s1),
		.edge_threshold (threshold_q),
		.out_valid      (out_valid),
		.edge_res       (edge_res),
		.centre_column  (centre_column),
		.centre_row     (centre_row)
	);

endmodule

FILE: tb/gradient_edge_threshold_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_edge_threshold_checker
// Watches the pixel, result and register ports of the edge detector. It keeps
// its own line stores, window and position counters, predicts the edge word of
// each accepted pixel that completes an interior neighborhood, and compares each
// accepted result word with the oldest prediction, register reads with written values.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [7:0]                 blue,
	input  logic [7:0]                 green,
	input  logic [7:0]                 red,
	input  logic                       start_of_frame,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       edge_res,
	input  logic [get_pkg::COL_W-1:0]  centre_column,
	input  logic [get_pkg::ROW_W-1:0]  centre_row,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [get_pkg::ADDR_W-1:0] paddr,
	input  logic [get_pkg::DATA_W-1:0] pwdata,
	input  logic [get_pkg::DATA_W-1:0] prdata,
	input  logic                       pready,
	output int                         fail_count,
	output int                         pending
);
	import get_pkg::*;

	// Q8 luma weights of red, green and blue.
	localparam int Y_RED   = 77;
	localparam int Y_GREEN = 150;
	localparam int Y_BLUE  = 29;

	typedef struct {
		logic             edge_flag;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} edge_word_t;

	luma_t            upper_line [MAX_WIDTH];
	luma_t            middle_line [MAX_WIDTH];
	luma_t            win [9];
	int unsigned      col_pos;
	int unsigned      row_pos;
	logic [CFG_W-1:0] threshold;
	logic [CFG_W-1:0] line_width;
	edge_word_t       expected_edges [$];

	// Move the position counters to the start of the next row; the row
	// counter wraps after the tallest image.
	function automatic void next_line();
		col_pos = 0;
		row_pos = (row_pos + 1 >= MAX_HEIGHT) ? 0 : row_pos + 1;
	endfunction

	// Take one pixel into the window and line stores. Returns 1 with the
	// expected edge word when the pixel completes an interior neighborhood.
	function automatic bit judge_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic sof, output edge_word_t word);
		int unsigned w;
		int unsigned c;
		int unsigned cc;
		int unsigned rr;
		longint      sx;
		longint      sy;
		longint      mag;
		longint      lim;
		luma_t       y;

		w = (line_width < MIN_WIDTH) ? MIN_WIDTH :
			(line_width > MAX_WIDTH) ? MAX_WIDTH : line_width;
		word = '{edge_flag: 1'b0, col: '0, row: '0};

		// A frame start or a width lowered under the current column opens a row.
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end else if (col_pos >= w) begin
			next_line();
		end

		y = luma_t'(Y_RED * int'(r) + Y_GREEN * int'(g) + Y_BLUE * int'(b));
		c = col_pos % MAX_WIDTH;

		// Shift the window left and fill its newest column from the stores.
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = upper_line[c];
		win[5] = middle_line[c];
		win[8] = y;
		upper_line[c]  = middle_line[c];
		middle_line[c] = y;

		cc = col_pos;
		rr = row_pos;
		if (cc + 1 >= w) begin
			next_line();
		end else begin
			col_pos = cc + 1;
		end

		if (cc < 2 || rr < 2) begin
			return 1'b0;
		end

		// Prewitt sums: right column minus left, bottom row minus top.
		sx = 0;
		sy = 0;
		for (int k = 0; k < 3; k++) begin
			sx += longint'(win[k*3+2]) - longint'(win[k*3]);
			sy += longint'(win[6+k]) - longint'(win[k]);
		end
		mag = sx * sx + sy * sy;
		lim = longint'(threshold) * 256;
		lim = lim * lim;

		word.edge_flag = (mag > lim);
		word.col       = COL_W'(cc - 1);
		word.row       = ROW_W'(rr - 1);
		return 1'b1;
	endfunction

	// Register port, result channel and pixel channel, in that order.
	always @(posedge clk or negedge arst_n) begin : monitor
		edge_word_t want;
		logic [CFG_W-1:0] reg_value;

		if (!arst_n) begin
			threshold  = THRESHOLD_RESET;
			line_width = WIDTH_RESET;
			for (int k = 0; k < 9; k++) begin
				win[k] = '0;
			end
			col_pos = 0;
			row_pos = 0;
			expected_edges.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_THRESHOLD: threshold  = pwdata[CFG_W-1:0];
						REG_WIDTH:     line_width = pwdata[CFG_W-1:0];
						default:       ;
					endcase
				end else begin
					reg_value = (reg_idx_t'(paddr[ADDR_W-1:2]) == REG_THRESHOLD) ?
						threshold : line_width;
					if (prdata !== DATA_W'(reg_value)) begin
						$display("%0t: register read at %0d: expected %0d, actual %0d",
							$time, paddr, reg_value, prdata);
						fail_count++;
					end
				end
			end

			if (out_valid && out_ready) begin
				if (expected_edges.size() == 0) begin
					$display("%0t: unexpected result: edge %0b column %0d row %0d",
						$time, edge_res, centre_column, centre_row);
					fail_count++;
				end else begin
					want = expected_edges.pop_front();
					if (edge_res !== want.edge_flag) begin
						$display("%0t: edge_res at column %0d row %0d: expected %0b, actual %0b",
							$time, want.col, want.row, want.edge_flag, edge_res);
						fail_count++;
					end
					if (centre_column !== want.col) begin
						$display("%0t: centre_column: expected %0d, actual %0d",
							$time, want.col, centre_column);
						fail_count++;
					end
					if (centre_row !== want.row) begin
						$display("%0t: centre_row: expected %0d, actual %0d",
							$time, want.row, centre_row);
						fail_count++;
					end
				end
			end

			if (in_valid && in_ready) begin
				if (judge_pixel(blue, green, red, start_of_frame, want)) begin
					expected_edges.push_back(want);
				end
			end

			pending <= expected_edges.size();
		end
	end

endmodule

FILE: tb/gradient_edge_threshold_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_edge_threshold_top_tb
// Drives raster pixel streams and register writes into the edge detector and
// gives the verdict. A short directed part covers the strongest gradient and
// the threshold boundary; random phases then vary threshold, image width
// (clamped values and widths lowered mid-row) and pixel data. Checking is
// done by the checker.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_top_tb;
	import get_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 8;
	localparam int PAD_W       = DATA_W - CFG_W;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        blue;
	logic [7:0]        green;
	logic [7:0]        red;
	logic              start_of_frame;
	logic              out_valid;
	logic              out_ready;
	logic              edge_res;
	logic [COL_W-1:0]  centre_column;
	logic [ROW_W-1:0]  centre_row;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int src_idle    = 30;
	int sink_idle   = 46;
	int cur_w       = int'(WIDTH_RESET);
	int line_pos    = 0;

	gradient_edge_threshold_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.start_of_frame (start_of_frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.edge_res       (edge_res),
		.centre_column  (centre_column),
		.centre_row     (centre_row),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	gradient_edge_threshold_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.start_of_frame (start_of_frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.edge_res       (edge_res),
		.centre_column  (centre_column),
		.centre_row     (centre_row),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// 12 ns clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The receiver stalls at random with the current idle rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= sink_idle);
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("gradient_edge_threshold_top_tb: FAIL");
			$finish;
		end
	end

	// Present one pixel word, with random idle cycles before it, and wait
	// until it is accepted. The column position is tracked so that a later
	// phase can lower the width under it.
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic sof);
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		blue           <= b;
		green          <= g;
		red            <= r;
		start_of_frame <= sof;
		do @(posedge clk); while (!in_ready);
		if (sof || line_pos >= cur_w) begin
			line_pos = 0;
		end
		line_pos = (line_pos + 1 >= cur_w) ? 0 : line_pos + 1;
	endtask

	// Wait until every expected result word has been taken, then let the
	// pipeline empty of pixels that give no result.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// One register access: setup, then access until pready, then idle with psel low.
	task automatic apb_access(input logic wr, input reg_idx_t idx,
			input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write both registers with junk in the unused upper bits and read them back.
	task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] wval);
		settle();
		apb_access(1'b1, REG_THRESHOLD, {PAD_W'($urandom), thr});
		apb_access(1'b1, REG_WIDTH, {PAD_W'($urandom), wval});
		apb_access(1'b0, REG_THRESHOLD, '0);
		apb_access(1'b0, REG_WIDTH, '0);
		cur_w = (wval < MIN_WIDTH) ? MIN_WIDTH : (wval > MAX_WIDTH) ? MAX_WIDTH : int'(wval);
	endtask

	function automatic logic [CFG_W-1:0] pick_threshold();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return CFG_W'(1083);
			3:       return CFG_W'($urandom_range(0, 2047));
			default: return CFG_W'($urandom_range(20, 300));
		endcase
	endfunction

	// One phase: new settings, then whole rows plus a partial one of random
	// pixels. A wider image must restart the frame so that no centre reads a
	// line store entry that was never written; a narrower one may carry on.
	task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] wval,
			input int rows, input bit noisy);
		int         old_w;
		int         n;
		bit         restart;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;

		old_w = cur_w;
		set_config(thr, wval);
		restart = (cur_w > old_w) || ($urandom_range(0, 3) == 0);
		n = rows * cur_w + $urandom_range(0, cur_w - 1);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					b = 8'd0;
					g = 8'd0;
					r = 8'd0;
				end
				3, 4, 5: begin
					b = 8'd255;
					g = 8'd255;
					r = 8'd255;
				end
				default: begin
					b = 8'($urandom);
					g = 8'($urandom);
					r = 8'($urandom);
				end
			endcase
			send_pixel(b, g, r, (i == 0 && restart) || (noisy && $urandom_range(0, 199) == 0));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] wval;

		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		blue           <= '0;
		green          <= '0;
		red            <= '0;
		start_of_frame <= 1'b0;
		out_ready      <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Strongest horizontal gradient, a black left column against white,
		// stays under the largest threshold. Width 2 acts as 3.
		set_config('1, CFG_W'(2));
		for (int i = 0; i < 9; i++) begin
			send_pixel((i % 3 == 0) ? 8'd0 : 8'd255, (i % 3 == 0) ? 8'd0 : 8'd255,
				(i % 3 == 0) ? 8'd0 : 8'd255, i == 0);
		end

		// A gradient of exactly 256 times the threshold is not an edge, one
		// threshold step lower it is. Width 0 acts as 3.
		for (int t = 75; t >= 74; t--) begin
			set_config(CFG_W'(t), '0);
			for (int i = 0; i < 9; i++) begin
				send_pixel(8'd0, (i == 5) ? 8'd128 : 8'd0, 8'd0, i == 0);
			end
		end

		// Random phases under three idle schedules.
		for (int seg = 0; seg < 3; seg++) begin
			src_idle  = (seg == 0) ? 30 : (seg == 1) ? 46 : 0;
			sink_idle = (seg == 0) ? 46 : (seg == 1) ? 30 : 0;
			for (int p = 0; p < 14; p++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						// Lower the width under the current column when possible.
						wval = (line_pos >= MIN_WIDTH) ?
							CFG_W'($urandom_range(MIN_WIDTH, line_pos)) :
							CFG_W'($urandom_range(0, MIN_WIDTH - 1));
					end
					2:       wval = CFG_W'($urandom_range(0, MIN_WIDTH - 1));
					default: wval = CFG_W'($urandom_range(MIN_WIDTH, 16));
				endcase
				run_phase(pick_threshold(), wval, $urandom_range(2, 7), 1'b1);
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("gradient_edge_threshold_top_tb: PASS");
		end else begin
			$display("gradient_edge_threshold_top_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/get_pkg.sv
hdl/get_ram.sv
hdl/get_front.sv
hdl/get_judge.sv
hdl/gradient_edge_threshold_top.sv
tb/gradient_edge_threshold_checker.sv
tb/gradient_edge_threshold_top_tb.sv
